/* rtl/pal_pkg.sv */
// Shared command codes, status codes and cell control types for the positional array list.
`timescale 1ns / 1ps

package pal_pkg;

  // Command codes carried in the command field.
  localparam logic [2:0] CmdRead    = 3'd0;
  localparam logic [2:0] CmdInsert  = 3'd1;
  localparam logic [2:0] CmdAppend  = 3'd2;
  localparam logic [2:0] CmdDelete  = 3'd3;
  localparam logic [2:0] CmdReplace = 3'd4;
  localparam logic [2:0] CmdClear   = 3'd5;

  // Status codes reported with every result.
  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StBadPos = 2'd1;
  localparam logic [1:0] StFull   = 2'd2;

  // Index width that covers the largest supported list.
  localparam int unsigned MaxIdxW = 10;

  // The action that every cell of the chain takes.
  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_WRITE,
    ACT_INSERT,
    ACT_DELETE
  } cell_act_e;

  // Control broadcast to the whole row of cells.
  typedef struct packed {
    cell_act_e            action;
    logic [MaxIdxW-1:0]   idx;
  } cell_ctl_t;

endpackage

/* rtl/pal_cell.sv */
// One storage cell of the list chain, holding the entry at a fixed position.
`timescale 1ns / 1ps

module pal_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned INDEX      = 0
) (
  input  logic                    clk_i,
  input  pal_pkg::cell_ctl_t      ctl_i,
  input  logic [DATA_WIDTH-1:0]   wdata_i,
  input  logic [DATA_WIDTH-1:0]   left_i,
  input  logic [DATA_WIDTH-1:0]   right_i,
  output logic [DATA_WIDTH-1:0]   data_o,
  output logic [DATA_WIDTH-1:0]   sel_o
);

  localparam logic [pal_pkg::MaxIdxW-1:0] MyIdx = pal_pkg::MaxIdxW'(INDEX);

  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;

  // Next entry: keep, overwrite, take the lower neighbor or the upper neighbor.
  always_comb begin
    data_d = data_q;
    case (ctl_i.action)
      pal_pkg::ACT_WRITE: begin
        if (ctl_i.idx == MyIdx) data_d = wdata_i;
      end
      pal_pkg::ACT_INSERT: begin
        if (MyIdx > ctl_i.idx) data_d = left_i;
        else if (MyIdx == ctl_i.idx) data_d = wdata_i;
      end
      pal_pkg::ACT_DELETE: begin
        if (MyIdx >= ctl_i.idx) data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  // Entry storage needs no reset; positions at or above the count are never read.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

  // Present the entry on the read tree only when this cell is addressed.
  assign sel_o = (ctl_i.idx == MyIdx) ? data_q : '0;

endmodule

/* rtl/pal_or_reduce.sv */
// Iterative four-to-one OR reduction that gathers the addressed entry from the cell row.
`timescale 1ns / 1ps

module pal_or_reduce #(
  parameter int unsigned NUM_LEAVES = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   load_i,
  input  logic [NUM_LEAVES-1:0][DATA_WIDTH-1:0]  leaf_i,
  output logic                                   done_o,
  output logic [DATA_WIDTH-1:0]                  result_o
);

  // Count the in-place folding steps needed to bring all lanes down to one.
  function automatic int unsigned fold_steps(int unsigned lanes);
    int unsigned n;
    int unsigned s;
    n = lanes;
    s = 0;
    for (int k = 0; k < 16; k++) begin
      if (n > 1) begin
        n = (n + 3) >> 2;
        s = s + 1;
      end
    end
    return s;
  endfunction

  localparam int unsigned Lanes = (NUM_LEAVES + 3) / 4;
  localparam int unsigned Steps = fold_steps(Lanes);
  localparam int unsigned CntW  = (Steps > 0) ? $clog2(Steps + 1) : 1;

  logic [Lanes-1:0][DATA_WIDTH-1:0] lane_q;
  logic [Lanes-1:0][DATA_WIDTH-1:0] lane_d;
  logic [CntW-1:0]                  cnt_q;

  // Each lane folds four leaves on load, or four lanes on a later step.
  for (genvar j = 0; j < Lanes; j++) begin : g_lane
    always_comb begin
      lane_d[j] = '0;
      if (load_i) begin
        for (int k = 0; k < 4; k++) begin
          if (4 * j + k < NUM_LEAVES) lane_d[j] = lane_d[j] | leaf_i[4 * j + k];
        end
      end else if (cnt_q != '0) begin
        for (int k = 0; k < 4; k++) begin
          if (4 * j + k < Lanes) lane_d[j] = lane_d[j] | lane_q[4 * j + k];
        end
      end else begin
        lane_d[j] = lane_q[j];
      end
    end
  end

  // Lane registers hold payload only.
  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  // Step counter: loaded with the fold count, runs down to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= CntW'(Steps);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  assign done_o   = (cnt_q == '0);
  assign result_o = lane_q[0];

endmodule

/* rtl/positional_array_list_unit.sv */
// Top level of the positional array list: command decode, cell chain and result register.
//
//   Channel   Direction  Width  Contents (lowest bit first)
//   s_axis    in         48     command[2:0], position[10:3], value[42:11]
//   m_axis    out        48     read_value[31:0], status[33:32], length[41:34],
//                                is_empty_flag[42], is_full_flag[43]
//
// Insert, append, replace, clear and the error cases need no gather: every cell shifts
// or writes at once, and a new command is taken each cycle while m_axis drains.
// Read and a successful delete gather the addressed entry through the four-to-one OR
// fold: the lanes load from the cells, then fold down to one before the result is held.
// Reset clears the count and the handshake state; cell contents are not cleared.
// A stalled m_axis holds its result and s_axis_tready stays low until it is taken.
`timescale 1ns / 1ps

module positional_array_list_unit #(
  parameter int unsigned CAPACITY   = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[2:0], position[10:3], value[42:11], zero fill above
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_value[31:0], status[33:32], length[41:34], is_empty_flag[42],
  // is_full_flag[43], zero fill above
  output logic [47:0] m_axis_tdata
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > 8) ? CntW : 8;

  typedef enum logic {
    ST_IDLE,
    ST_GATHER
  } state_e;

  // Input fields.
  logic [2:0]  command;
  logic [7:0]  position;
  logic [31:0] value;

  assign command  = s_axis_tdata[2:0];
  assign position = s_axis_tdata[10:3];
  assign value    = s_axis_tdata[42:11];

  state_e               state_q;
  logic [CntW-1:0]      count_q;
  logic                 out_valid_q;
  logic                 out_valid_d;
  logic [31:0]          out_read_q;
  logic [1:0]           out_status_q;
  logic [7:0]           out_len_q;
  logic                 out_empty_q;
  logic                 out_full_q;

  logic                 accept;
  logic [CntW-1:0]      count_d;
  logic [1:0]           status_d;
  logic                 need_rd;
  pal_pkg::cell_ctl_t   ctl;
  logic [CmpW-1:0]      pos_w;
  logic [CmpW-1:0]      cnt_w;
  logic                 full_now;
  logic signed [63:0]   val_ext;
  logic [DATA_WIDTH-1:0] wdata;

  logic [CAPACITY-1:0][DATA_WIDTH-1:0] cell_data;
  logic [CAPACITY-1:0][DATA_WIDTH-1:0] cell_sel;
  logic                  rd_done;
  logic [DATA_WIDTH-1:0] rd_result;
  logic signed [63:0]    rd_ext;

  // A command is taken when idle and the result register is free or being freed.
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign pos_w    = CmpW'(position);
  assign cnt_w    = CmpW'(count_q);
  assign full_now = (count_q == CntW'(CAPACITY));

  // Stored words keep the low bits of the sign-extended value field.
  assign val_ext = 64'($signed(value));
  assign wdata   = val_ext[DATA_WIDTH-1:0];

  // Decode the command against the current count.
  always_comb begin
    count_d    = count_q;
    status_d   = pal_pkg::StOk;
    need_rd    = 1'b0;
    ctl.action = pal_pkg::ACT_HOLD;
    ctl.idx    = pal_pkg::MaxIdxW'(position);
    case (command)
      pal_pkg::CmdRead: begin
        if (pos_w >= cnt_w) status_d = pal_pkg::StBadPos;
        else need_rd = 1'b1;
      end
      pal_pkg::CmdInsert: begin
        if (pos_w > cnt_w) begin
          status_d = pal_pkg::StBadPos;
        end else if (full_now) begin
          status_d = pal_pkg::StFull;
        end else begin
          ctl.action = pal_pkg::ACT_INSERT;
          count_d    = count_q + CntW'(1);
        end
      end
      pal_pkg::CmdAppend: begin
        if (full_now) begin
          status_d = pal_pkg::StFull;
        end else begin
          ctl.action = pal_pkg::ACT_WRITE;
          ctl.idx    = pal_pkg::MaxIdxW'(count_q);
          count_d    = count_q + CntW'(1);
        end
      end
      pal_pkg::CmdDelete: begin
        if (pos_w >= cnt_w) begin
          status_d = pal_pkg::StBadPos;
        end else begin
          need_rd    = 1'b1;
          ctl.action = pal_pkg::ACT_DELETE;
          count_d    = count_q - CntW'(1);
        end
      end
      pal_pkg::CmdReplace: begin
        if (pos_w >= cnt_w) status_d = pal_pkg::StBadPos;
        else ctl.action = pal_pkg::ACT_WRITE;
      end
      pal_pkg::CmdClear: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    // Cells move only on an accepted transaction.
    if (!accept) ctl.action = pal_pkg::ACT_HOLD;
  end

  // Row of cells; each one hands its entry to both neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_right
      assign right = cell_data[i+1];
    end
    pal_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .wdata_i (wdata),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .sel_o   (cell_sel[i])
    );
  end

  // Gather the addressed entry, captured before the cells update.
  pal_or_reduce #(
    .NUM_LEAVES (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_reduce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept && need_rd),
    .leaf_i   (cell_sel),
    .done_o   (rd_done),
    .result_o (rd_result)
  );

  assign rd_ext = 64'($signed(rd_result));

  // Result valid: set when a result is ready, cleared when it is taken.
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (accept && !need_rd) out_valid_d = 1'b1;
    if ((state_q == ST_GATHER) && rd_done) out_valid_d = 1'b1;
  end

  // Sequencer with the count and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      out_read_q   <= '0;
      out_status_q <= pal_pkg::StOk;
      out_len_q    <= '0;
      out_empty_q  <= 1'b1;
      out_full_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            count_q      <= count_d;
            out_status_q <= status_d;
            out_len_q    <= 8'(count_d);
            out_empty_q  <= (count_d == '0);
            out_full_q   <= (count_d == CntW'(CAPACITY));
            out_read_q   <= '0;
            if (need_rd) begin
              state_q <= ST_GATHER;
            end
          end
        end
        ST_GATHER: begin
          if (rd_done) begin
            out_read_q <= rd_ext[31:0];
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_full_q, out_empty_q, out_len_q, out_status_q,
                          out_read_q};

endmodule
